### sv/mrls_pkg.sv
// shared types, codes and helpers for the movem register list sequencer
// no dependencies; used by the interfaces and the top level
package mrls_pkg;

   localparam int NUM_REGS = 16;
   localparam int REG_IDX_W = $clog2(NUM_REGS);

   localparam logic       FUNC_STORE   = 1'b0;
   localparam logic       FUNC_LOAD    = 1'b1;
   localparam logic [1:0] MODE_CONTROL = 2'd0;
   localparam logic [1:0] MODE_PREDEC  = 2'd1;
   localparam logic [1:0] MODE_POSTINC = 2'd2;
   localparam logic [31:0] SIZE_WORD   = 32'd2;
   localparam logic [31:0] SIZE_LONG   = 32'd4;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_EMPTY
   } state_type;

   typedef struct packed {
      logic        func;
      logic        long_size;
      logic [1:0]  addr_mode;
      logic [15:0] reg_mask;
      logic [31:0] start_address;
      logic [2:0]  base_register;
   } req_payload_type;

   typedef struct packed {
      logic [31:0] access_address;
      logic [3:0]  register_index;
      logic        is_write;
      logic        sign_extend;
      logic        no_access;
      logic        writeback_enable;
      logic [2:0]  writeback_register;
      logic [31:0] writeback_address;
      logic        last;
   } rsp_payload_type;

   // index of the lowest set bit, zero when the mask is empty
   function automatic logic [REG_IDX_W-1:0] lowest_index(input logic [NUM_REGS-1:0] mask);
      logic [NUM_REGS-1:0]  onehot;
      logic [REG_IDX_W-1:0] idx;
      onehot = mask & (~mask + NUM_REGS'(1));
      idx = '0;
      for (int i = 0; i < NUM_REGS; i++) begin
         if (onehot[i]) begin
            idx = idx | REG_IDX_W'(i);
         end
      end
      return idx;
   endfunction

endpackage

### sv/mrls_if.sv
// valid/ready channels for requests and responses of the movem sequencer
// depends on mrls_pkg for the payload types
interface mrls_req_if;
   import mrls_pkg::*;
   logic            valid;
   logic            ready;
   req_payload_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface mrls_rsp_if;
   import mrls_pkg::*;
   logic            valid;
   logic            ready;
   rsp_payload_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

### sv/movem_register_list_sequencer_top.sv
// Movem register list sequencer. A request is taken only while the block is idle; it
// then produces one bus access per set mask bit, lowest mask bit first (a single
// no-access response for an empty mask), one result per cycle as long as the response
// side takes them. The pace is set by the single 32-bit address adder, which steps the
// running address once per result. Results pass through an output register, so the last
// response of one request may still be waiting while the next request is accepted.
// depends on mrls_pkg and the channel interfaces in mrls_if.sv
module movem_register_list_sequencer_top (
   input  logic            clock,
   input  logic            reset,
   mrls_req_if.sink        req_ch,
   mrls_rsp_if.source      rsp_ch
);
   import mrls_pkg::*;

   state_type            state_ff, state_in;
   logic [NUM_REGS-1:0]  mask_ff, mask_in;
   logic [31:0]          cur_ff, cur_in;
   logic                 func_ff, func_in;
   logic                 long_ff, long_in;
   logic                 predec_ff, predec_in;
   logic                 wb_ff, wb_in;
   logic [2:0]           base_ff, base_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_payload_type      rsp_data_ff, rsp_data_in;

   logic                 accept;
   logic                 step;
   logic                 req_predec;
   logic                 req_postinc;
   logic [31:0]          op_a;
   logic [31:0]          op_size;
   logic                 subtract;
   logic [31:0]          sum;
   logic [NUM_REGS-1:0]  mask_rest;
   logic [REG_IDX_W-1:0] bit_idx;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign accept       = req_ch.valid && req_ch.ready;
   assign step         = !rsp_valid_ff || rsp_ch.ready;
   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.data  = rsp_data_ff;

   assign req_predec  = (req_ch.data.addr_mode == MODE_PREDEC) &&
                        (req_ch.data.func == FUNC_STORE);
   assign req_postinc = (req_ch.data.addr_mode == MODE_POSTINC) &&
                        (req_ch.data.func == FUNC_LOAD);

   // shared address adder: preloads ea + size for predecrement, then steps per access
   always_comb begin
      if (state_ff == ST_IDLE) begin
         op_a     = req_ch.data.start_address;
         op_size  = req_ch.data.long_size ? SIZE_LONG : SIZE_WORD;
         subtract = 1'b0;
      end else begin
         op_a     = cur_ff;
         op_size  = long_ff ? SIZE_LONG : SIZE_WORD;
         subtract = predec_ff;
      end
      sum = subtract ? (op_a - op_size) : (op_a + op_size);
   end

   assign bit_idx   = lowest_index(mask_ff);
   assign mask_rest = mask_ff & (mask_ff - NUM_REGS'(1));

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = (req_ch.data.reg_mask == '0) ? ST_EMPTY : ST_RUN;
            end
         end
         ST_RUN: begin
            if (step && (mask_rest == '0)) begin
               state_in = ST_IDLE;
            end
         end
         ST_EMPTY: begin
            if (step) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      mask_in      = mask_ff;
      cur_in       = cur_ff;
      func_in      = func_ff;
      long_in      = long_ff;
      predec_in    = predec_ff;
      wb_in        = wb_ff;
      base_in      = base_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_data_in  = rsp_data_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               mask_in   = req_ch.data.reg_mask;
               cur_in    = req_predec ? sum : req_ch.data.start_address;
               func_in   = req_ch.data.func;
               long_in   = req_ch.data.long_size;
               predec_in = req_predec;
               wb_in     = req_predec || req_postinc;
               base_in   = req_ch.data.base_register;
            end
         end
         ST_RUN: begin
            if (step) begin
               mask_in      = mask_rest;
               cur_in       = sum;
               rsp_valid_in = 1'b1;
               rsp_data_in.access_address     = predec_ff ? sum : cur_ff;
               rsp_data_in.register_index     = predec_ff ? ~bit_idx : bit_idx;
               rsp_data_in.is_write           = (func_ff == FUNC_STORE);
               rsp_data_in.sign_extend        = (func_ff == FUNC_LOAD) && !long_ff;
               rsp_data_in.no_access          = 1'b0;
               rsp_data_in.last               = (mask_rest == '0);
               rsp_data_in.writeback_enable   = wb_ff && (mask_rest == '0);
               rsp_data_in.writeback_register = (wb_ff && (mask_rest == '0)) ? base_ff : 3'd0;
               rsp_data_in.writeback_address  = (wb_ff && (mask_rest == '0)) ? sum : 32'd0;
            end
         end
         ST_EMPTY: begin
            if (step) begin
               rsp_valid_in = 1'b1;
               rsp_data_in.access_address     = 32'd0;
               rsp_data_in.register_index     = '0;
               rsp_data_in.is_write           = 1'b0;
               rsp_data_in.sign_extend        = 1'b0;
               rsp_data_in.no_access          = 1'b1;
               rsp_data_in.last               = 1'b1;
               rsp_data_in.writeback_enable   = wb_ff;
               rsp_data_in.writeback_register = wb_ff ? base_ff : 3'd0;
               rsp_data_in.writeback_address  = wb_ff ? cur_ff : 32'd0;
            end
         end
         default: begin
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         mask_ff      <= '0;
         cur_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         mask_ff      <= mask_in;
         cur_ff       <= cur_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff     <= func_in;
      long_ff     <= long_in;
      predec_ff   <= predec_in;
      wb_ff       <= wb_in;
      base_ff     <= base_in;
      rsp_data_ff <= rsp_data_in;
   end

   a_empty_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.data.no_access) |-> rsp_ch.data.last)
      else $error("empty-mask response not marked last");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> !req_ch.ready)
      else $error("request accepted while a move is still being sequenced");

   a_mid_list_running: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && !rsp_ch.data.last) |-> (state_ff == ST_RUN))
      else $error("non-final response while sequencer not running");

   a_wb_only_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.data.writeback_enable) |-> rsp_ch.data.last)
      else $error("writeback on a non-final response");

endmodule

### test/tb.sv
// self-checking bench for movem_register_list_sequencer_top: directed table, then random requests
// every response is checked in order against its typed row or a behavioral model of the list walk
// depends on mrls_pkg, mrls_req_if and mrls_rsp_if
module tb;
   import mrls_pkg::*;

   localparam int CYCLE_LIMIT   = 300000;
   localparam int RANDOM_COUNT  = 108;
   localparam int CALM_TAIL     = 25;
   localparam int LONG_HOLD     = 80;
   localparam int HOLD_AT       = 37;
   localparam int PAUSE_AT      = 60;
   localparam int DRAIN_CYCLES  = 40;

   typedef struct {
      req_payload_type rq;
      bit              typed;
      rsp_payload_type want;
   } stim_row_type;

   logic clock;
   logic reset;

   mrls_req_if req_ch ();
   mrls_rsp_if rsp_ch ();

   movem_register_list_sequencer_top u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   rsp_payload_type expected_accesses[$];
   stim_row_type    directed_rows[$];
   bit              offer_typed;
   rsp_payload_type offer_want;
   bit              calm_phase;
   int              accepted_requests;
   int              mismatch_count;
   int              cycle_count;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   function automatic req_payload_type movem_req(input logic func, input logic long_size,
                                                 input logic [1:0] mode, input logic [15:0] mask,
                                                 input logic [31:0] ea, input logic [2:0] base);
      req_payload_type rq;
      rq.func          = func;
      rq.long_size     = long_size;
      rq.addr_mode     = mode;
      rq.reg_mask      = mask;
      rq.start_address = ea;
      rq.base_register = base;
      return rq;
   endfunction

   // a request that produces exactly one response, so it is also the last one
   function automatic rsp_payload_type single_access(input logic [31:0] addr,
                                                     input logic [3:0] idx, input logic wr,
                                                     input logic sx, input logic na,
                                                     input logic wbe, input logic [2:0] wbr,
                                                     input logic [31:0] wba);
      rsp_payload_type a;
      a.access_address     = addr;
      a.register_index     = idx;
      a.is_write           = wr;
      a.sign_extend        = sx;
      a.no_access          = na;
      a.writeback_enable   = wbe;
      a.writeback_register = wbr;
      a.writeback_address  = wba;
      a.last               = 1'b1;
      return a;
   endfunction

   task automatic add_row(input req_payload_type rq, input bit typed, input rsp_payload_type want);
      stim_row_type row;
      row.rq    = rq;
      row.typed = typed;
      row.want  = want;
      directed_rows.push_back(row);
   endtask

   // walks the mask and queues one bus access per set bit, or one no-access entry for an empty mask
   function automatic void expand_register_list(input req_payload_type rq);
      logic [31:0]     xfer_size;
      logic [31:0]     addr_run;
      logic            predec;
      logic            postinc;
      rsp_payload_type acc;
      int              produced;
      xfer_size = rq.long_size ? SIZE_LONG : SIZE_WORD;
      predec    = (rq.addr_mode == MODE_PREDEC) && (rq.func == FUNC_STORE);
      postinc   = (rq.addr_mode == MODE_POSTINC) && (rq.func == FUNC_LOAD);
      addr_run  = predec ? rq.start_address + xfer_size : rq.start_address;
      produced  = 0;
      for (int i = 0; i < NUM_REGS; i++) begin
         if (rq.reg_mask[i]) begin
            acc = '0;
            if (predec) begin
               addr_run = addr_run - xfer_size;
               acc.access_address = addr_run;
            end else begin
               acc.access_address = addr_run;
               addr_run = addr_run + xfer_size;
            end
            // predecrement walks the list reversed: bit 0 is A7
            acc.register_index = predec ? 4'(15 - i) : 4'(i);
            acc.is_write       = (rq.func == FUNC_STORE);
            acc.sign_extend    = (rq.func == FUNC_LOAD) && !rq.long_size;
            expected_accesses.push_back(acc);
            produced++;
         end
      end
      if (produced == 0) begin
         acc = '0;
         acc.no_access = 1'b1;
         expected_accesses.push_back(acc);
      end
      acc = expected_accesses.pop_back();
      acc.last = 1'b1;
      if (predec || postinc) begin
         acc.writeback_enable   = 1'b1;
         acc.writeback_register = rq.base_register;
         acc.writeback_address  = addr_run;
      end
      expected_accesses.push_back(acc);
   endfunction

   function automatic string access_text(input rsp_payload_type a);
      return $sformatf("addr=%h reg=%0d wr=%b sx=%b na=%b wbe=%b wbr=%0d wba=%h last=%b",
                       a.access_address, a.register_index, a.is_write, a.sign_extend,
                       a.no_access, a.writeback_enable, a.writeback_register,
                       a.writeback_address, a.last);
   endfunction

   task automatic note_failure(input string msg);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $display("[%0d] mismatch: %s", cycle_count, msg);
      end
   endtask

   task automatic check_access(input rsp_payload_type got);
      rsp_payload_type want;
      if (expected_accesses.size() == 0) begin
         note_failure({"response with nothing pending: ", access_text(got)});
         return;
      end
      want = expected_accesses.pop_front();
      if (got.access_address !== want.access_address ||
          got.register_index !== want.register_index ||
          got.is_write !== want.is_write ||
          got.sign_extend !== want.sign_extend ||
          got.no_access !== want.no_access ||
          got.writeback_enable !== want.writeback_enable ||
          got.writeback_register !== want.writeback_register ||
          got.writeback_address !== want.writeback_address ||
          got.last !== want.last) begin
         note_failure({"\n   expected ", access_text(want), "\n   actual   ", access_text(got)});
      end
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            check_access(rsp_ch.data);
         end
         if (req_ch.valid && req_ch.ready) begin
            accepted_requests++;
            if (offer_typed) begin
               expected_accesses.push_back(offer_want);
            end else begin
               expand_register_list(req_ch.data);
            end
         end
      end
   end

   function automatic req_payload_type random_movem();
      req_payload_type rq;
      int              pick;
      rq.func      = 1'($urandom);
      rq.long_size = 1'($urandom);
      pick = $urandom_range(0, 99);
      // mostly the well-formed pairs that carry a writeback
      if (pick < 75) begin
         rq.addr_mode = (rq.func == FUNC_STORE) ? MODE_PREDEC : MODE_POSTINC;
      end else if (pick < 85) begin
         rq.addr_mode = MODE_CONTROL;
      end else begin
         rq.addr_mode = 2'($urandom);
      end
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
         rq.reg_mask = '0;
      end else if (pick < 20) begin
         rq.reg_mask = '1;
      end else if (pick < 60) begin
         rq.reg_mask = '0;
         repeat ($urandom_range(1, 3)) rq.reg_mask[$urandom_range(0, 15)] = 1'b1;
      end else begin
         rq.reg_mask = 16'($urandom);
      end
      pick = $urandom_range(0, 99);
      if (pick < 20) begin
         rq.start_address = 32'hFFFF_FF00 | 32'($urandom_range(0, 255));
      end else if (pick < 40) begin
         rq.start_address = 32'($urandom_range(0, 255));
      end else begin
         rq.start_address = $urandom;
      end
      rq.base_register = 3'($urandom);
      return rq;
   endfunction

   task automatic offer_request(input req_payload_type rq, input bit typed,
                                input rsp_payload_type want);
      req_ch.data  = rq;
      offer_typed  = typed;
      offer_want   = want;
      req_ch.valid = 1'b1;
      do @(posedge clock); while (!(req_ch.valid && req_ch.ready));
      @(negedge clock);
   endtask

   task automatic maybe_idle();
      if (!calm_phase && $urandom_range(0, 4) == 0) begin
         req_ch.valid = 1'b0;
         repeat ($urandom_range(1, 7)) @(negedge clock);
      end
   endtask

   // receiver: random stall bursts, one long hold-off, none in the calm tail
   initial begin
      int gap_left;
      bit long_hold_done;
      gap_left       = 0;
      long_hold_done = 1'b0;
      rsp_ch.ready   = 1'b0;
      forever begin
         @(negedge clock);
         if (gap_left > 0) begin
            rsp_ch.ready = 1'b0;
            gap_left--;
         end else if (!long_hold_done && accepted_requests >= HOLD_AT) begin
            rsp_ch.ready   = 1'b0;
            gap_left       = LONG_HOLD - 1;
            long_hold_done = 1'b1;
         end else if (!calm_phase && $urandom_range(0, 7) == 0) begin
            rsp_ch.ready = 1'b0;
            gap_left     = $urandom_range(1, 7) - 1;
         end else begin
            rsp_ch.ready = 1'b1;
         end
      end
   end

   initial begin
      rsp_payload_type none;
      none              = '0;
      reset             = 1'b1;
      req_ch.valid      = 1'b0;
      req_ch.data       = '0;
      offer_typed       = 1'b0;
      offer_want        = '0;
      calm_phase        = 1'b0;
      accepted_requests = 0;
      mismatch_count    = 0;
      cycle_count       = 0;

      // empty masks, with and without writeback
      add_row(movem_req(FUNC_STORE, 1'b0, MODE_CONTROL, 16'h0000, 32'h1234_5678, 3'd3), 1,
              single_access(32'h0, 4'd0, 1'b0, 1'b0, 1'b1, 1'b0, 3'd0, 32'h0));
      add_row(movem_req(FUNC_LOAD, 1'b0, MODE_POSTINC, 16'h0000, 32'hFFFF_FFFF, 3'd7), 1,
              single_access(32'h0, 4'd0, 1'b0, 1'b0, 1'b1, 1'b1, 3'd7, 32'hFFFF_FFFF));
      add_row(movem_req(FUNC_STORE, 1'b0, MODE_PREDEC, 16'h0000, 32'hFFFF_FFFE, 3'd0), 1,
              single_access(32'h0, 4'd0, 1'b0, 1'b0, 1'b1, 1'b1, 3'd0, 32'h0000_0000));
      add_row(movem_req(FUNC_STORE, 1'b1, MODE_PREDEC, 16'h0000, 32'h0000_1000, 3'd5), 1,
              single_access(32'h0, 4'd0, 1'b0, 1'b0, 1'b1, 1'b1, 3'd5, 32'h0000_1004));
      add_row(movem_req(FUNC_LOAD, 1'b1, 2'd3, 16'h0000, 32'hDEAD_BEEF, 3'd6), 1,
              single_access(32'h0, 4'd0, 1'b0, 1'b0, 1'b1, 1'b0, 3'd0, 32'h0));
      // single register, corners of the list and of the address space
      add_row(movem_req(FUNC_STORE, 1'b1, MODE_PREDEC, 16'h0001, 32'h0000_1000, 3'd6), 1,
              single_access(32'h0000_1000, 4'd15, 1'b1, 1'b0, 1'b0, 1'b1, 3'd6, 32'h0000_1000));
      add_row(movem_req(FUNC_STORE, 1'b0, MODE_PREDEC, 16'h8000, 32'h0000_0100, 3'd2), 1,
              single_access(32'h0000_0100, 4'd0, 1'b1, 1'b0, 1'b0, 1'b1, 3'd2, 32'h0000_0100));
      add_row(movem_req(FUNC_LOAD, 1'b0, MODE_POSTINC, 16'h8000, 32'hFFFF_FFFE, 3'd4), 1,
              single_access(32'hFFFF_FFFE, 4'd15, 1'b0, 1'b1, 1'b0, 1'b1, 3'd4, 32'h0));
      add_row(movem_req(FUNC_LOAD, 1'b1, MODE_POSTINC, 16'h0001, 32'h0000_0000, 3'd1), 1,
              single_access(32'h0, 4'd0, 1'b0, 1'b0, 1'b0, 1'b1, 3'd1, 32'h0000_0004));
      add_row(movem_req(FUNC_STORE, 1'b1, MODE_CONTROL, 16'h0400, 32'hFFFF_FFFC, 3'd7), 1,
              single_access(32'hFFFF_FFFC, 4'd10, 1'b1, 1'b0, 1'b0, 1'b0, 3'd0, 32'h0));
      // mode and direction disagree: plain control transfer
      add_row(movem_req(FUNC_LOAD, 1'b0, MODE_PREDEC, 16'h0002, 32'h0000_2000, 3'd3), 1,
              single_access(32'h0000_2000, 4'd1, 1'b0, 1'b1, 1'b0, 1'b0, 3'd0, 32'h0));
      add_row(movem_req(FUNC_STORE, 1'b1, MODE_POSTINC, 16'h0000, 32'h0000_3000, 3'd2), 1,
              single_access(32'h0, 4'd0, 1'b0, 1'b0, 1'b1, 1'b0, 3'd0, 32'h0));
      // full and patterned lists
      add_row(movem_req(FUNC_STORE, 1'b1, MODE_CONTROL, 16'hFFFF, 32'h0000_0000, 3'd0), 0, none);
      add_row(movem_req(FUNC_LOAD, 1'b0, MODE_CONTROL, 16'hFFFF, 32'hFFFF_FFF0, 3'd1), 0, none);
      add_row(movem_req(FUNC_STORE, 1'b1, MODE_PREDEC, 16'hFFFF, 32'h0000_003C, 3'd0), 0, none);
      add_row(movem_req(FUNC_STORE, 1'b0, MODE_PREDEC, 16'hFFFF, 32'h0000_0010, 3'd7), 0, none);
      add_row(movem_req(FUNC_LOAD, 1'b1, MODE_POSTINC, 16'hFFFF, 32'hFFFF_FFF8, 3'd7), 0, none);
      add_row(movem_req(FUNC_LOAD, 1'b0, MODE_POSTINC, 16'hAAAA, 32'h8000_0000, 3'd2), 0, none);
      add_row(movem_req(FUNC_STORE, 1'b0, 2'd3, 16'h5555, 32'h7FFF_FFFE, 3'd5), 0, none);
      add_row(movem_req(FUNC_LOAD, 1'b1, 2'd3, 16'h00F0, 32'h0000_0040, 3'd6), 0, none);
      add_row(movem_req(FUNC_STORE, 1'b0, MODE_POSTINC, 16'h0F00, 32'h0001_0000, 3'd4), 0, none);
      add_row(movem_req(FUNC_LOAD, 1'b1, MODE_PREDEC, 16'hF00F, 32'hFFFF_FFF0, 3'd3), 0, none);

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed_rows[i]) begin
         maybe_idle();
         offer_request(directed_rows[i].rq, directed_rows[i].typed, directed_rows[i].want);
      end

      for (int n = 0; n < RANDOM_COUNT; n++) begin
         if (n == RANDOM_COUNT - CALM_TAIL) begin
            calm_phase = 1'b1;
         end
         if (n == PAUSE_AT) begin
            // let the block drain completely before going on
            req_ch.valid = 1'b0;
            while (expected_accesses.size() != 0) @(negedge clock);
         end
         maybe_idle();
         offer_request(random_movem(), 1'b0, none);
      end
      req_ch.valid = 1'b0;

      while (expected_accesses.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatch_count == 0 && expected_accesses.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
